>>> rtl/tlpl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlpl_pkg;

    localparam int TAG_W    = 16;
    localparam int SEV_W    = 2;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 8;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_TAKE = 1'b1;

    localparam logic [SEV_W-1:0] SEV_REGULAR = 2'd0;
    localparam logic [SEV_W-1:0] SEV_BAD     = 2'd1;
    localparam logic [SEV_W-1:0] SEV_WORST   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TAKEN = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_GRAB,
        S_SHIFT,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

>>> rtl/tlpl_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tlpl_req_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [tlpl_pkg::TAG_W-1:0]  tag;
    logic [tlpl_pkg::SEV_W-1:0]  severity;

    modport source (output valid, output action, output tag, output severity, input ready);
    modport sink   (input valid, input action, input tag, input severity, output ready);
endinterface

interface tlpl_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [tlpl_pkg::STATUS_W-1:0]  status;
    logic [tlpl_pkg::TAG_W-1:0]     taken_tag;
    logic [tlpl_pkg::SEV_W-1:0]     taken_severity;
    logic [tlpl_pkg::FILL_W-1:0]    fill;

    modport source (output valid, output status, output taken_tag, output taken_severity,
                    output fill, input ready);
    modport sink   (input valid, input status, input taken_tag, input taken_severity,
                    input fill, output ready);
endinterface

`default_nettype wire

>>> rtl/three_level_priority_list.sv
// Add, full and empty requests go from idle straight to the response state.
// A take runs the scan (ended early by a worst entry), fetch, grab, shift (when entries
// follow the pick) and response states; scan and shift handle one entry per cycle.
// Throughput: one request at a time; ready returns once the result is registered.
// Reset: rst_n clears the entry count, sequencer and output valid; entry memory
// is left unset and only entries below the count are ever used.
`timescale 1ns / 1ps
`default_nettype none

module three_level_priority_list #(
    parameter int CAPACITY = 128,
    parameter int TAG_BITS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tlpl_req_if.sink   req,
    tlpl_rsp_if.source rsp
);

    import tlpl_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    typedef struct packed {
        logic [TW-1:0]    tag;
        logic [SEV_W-1:0] sev;
    } entry_t;

    entry_t entry_mem [CAPACITY];
    entry_t rd_data_reg;
    entry_t wr_data;
    logic   wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [CW-1:0] pick_reg, pick_next;
    logic [CW-1:0] dst_reg, dst_next;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [TW-1:0]       res_tag_reg, res_tag_next;
    logic [SEV_W-1:0]    res_sev_reg, res_sev_next;

    logic                out_vld_reg, out_vld_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [TAG_W-1:0]    out_tag_reg, out_tag_next;
    logic [SEV_W-1:0]    out_sev_reg, out_sev_next;
    logic [FILL_W-1:0]   out_fill_reg, out_fill_next;

    logic                accept;
    logic                has_room;
    logic                issue;
    logic [CW-1:0]       cmp_idx;
    logic [CW-1:0]       pick_inc;
    logic [CW-1:0]       dst_inc;
    logic [CW-1:0]       dst_inc2;
    logic                load_out;
    logic [SEV_W-1:0]    sev_clean;
    logic [TAG_W+TW-1:0] tag_ext;
    logic [FILL_W+CW-1:0] fill_ext;

    assign accept    = req.valid && req.ready;
    assign has_room  = count_reg < CW'(CAPACITY);
    assign issue     = idx_reg < count_reg;
    assign cmp_idx   = idx_reg - CW'(1);
    assign pick_inc  = pick_reg + CW'(1);
    assign dst_inc   = dst_reg + CW'(1);
    assign dst_inc2  = dst_reg + CW'(2);
    assign load_out  = (state_reg == S_RESP) && (!out_vld_reg || rsp.ready);
    assign sev_clean = (req.severity > SEV_WORST) ? SEV_REGULAR : req.severity;
    assign tag_ext   = {{TAG_W{1'b0}}, res_tag_reg};
    assign fill_ext  = {{FILL_W{1'b0}}, count_reg};

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_vld_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.taken_tag      = out_tag_reg;
    assign rsp.taken_severity = out_sev_reg;
    assign rsp.fill           = out_fill_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.action == ACT_TAKE && count_reg != '0)
                        state_next = S_SCAN;
                    else
                        state_next = S_RESP;
                end
            end
            S_SCAN:
            begin
                if (cmp_vld_reg && (rd_data_reg.sev == SEV_WORST || idx_reg == count_reg))
                    state_next = S_FETCH;
            end
            S_FETCH:
                state_next = S_GRAB;
            S_GRAB:
            begin
                if (pick_inc < count_reg)
                    state_next = S_SHIFT;
                else
                    state_next = S_RESP;
            end
            S_SHIFT:
            begin
                if (!(dst_inc2 < count_reg))
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next      = count_reg;
        idx_next        = idx_reg;
        cmp_vld_next    = cmp_vld_reg;
        pick_next       = pick_reg;
        dst_next        = dst_reg;
        res_status_next = res_status_reg;
        res_tag_next    = res_tag_reg;
        res_sev_next    = res_sev_reg;
        wr_en           = 1'b0;
        wr_addr         = count_reg[AW-1:0];
        wr_data         = rd_data_reg;
        rd_addr         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                res_tag_next = '0;
                res_sev_next = SEV_REGULAR;
                idx_next     = '0;
                cmp_vld_next = 1'b0;
                pick_next    = '0;
                if (accept)
                begin
                    if (req.action == ACT_ADD)
                    begin
                        if (has_room)
                        begin
                            wr_en           = 1'b1;
                            wr_data.tag     = req.tag[TW-1:0];
                            wr_data.sev     = sev_clean;
                            count_next      = count_reg + CW'(1);
                            res_status_next = ST_ADDED;
                        end
                        else
                        begin
                            res_status_next = ST_FULL;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = ST_EMPTY;
                    end
                end
            end
            S_SCAN:
            begin
                rd_addr      = idx_reg[AW-1:0];
                cmp_vld_next = issue;
                idx_next     = idx_reg + CW'(1);
                if (cmp_vld_reg && rd_data_reg.sev != SEV_REGULAR)
                    pick_next = cmp_idx;
            end
            S_FETCH:
                rd_addr = pick_reg[AW-1:0];
            S_GRAB:
            begin
                rd_addr         = pick_inc[AW-1:0];
                dst_next        = pick_reg;
                res_tag_next    = rd_data_reg.tag;
                res_sev_next    = rd_data_reg.sev;
                res_status_next = ST_TAKEN;
                if (!(pick_inc < count_reg))
                    count_next = count_reg - CW'(1);
            end
            S_SHIFT:
            begin
                wr_en    = 1'b1;
                wr_addr  = dst_reg[AW-1:0];
                rd_addr  = dst_inc2[AW-1:0];
                dst_next = dst_inc;
                if (!(dst_inc2 < count_reg))
                    count_next = count_reg - CW'(1);
            end
            S_RESP:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_vld_next    = out_vld_reg;
        out_status_next = out_status_reg;
        out_tag_next    = out_tag_reg;
        out_sev_next    = out_sev_reg;
        out_fill_next   = out_fill_reg;
        if (rsp.ready)
            out_vld_next = 1'b0;
        if (load_out)
        begin
            out_vld_next    = 1'b1;
            out_status_next = res_status_reg;
            out_tag_next    = tag_ext[TAG_W-1:0];
            out_sev_next    = res_sev_reg;
            out_fill_next   = fill_ext[FILL_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            entry_mem[wr_addr] <= wr_data;
        rd_data_reg <= entry_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg       <= pick_next;
        dst_reg        <= dst_next;
        res_status_reg <= res_status_next;
        res_tag_reg    <= res_tag_next;
        res_sev_reg    <= res_sev_next;
        out_status_reg <= out_status_next;
        out_tag_reg    <= out_tag_next;
        out_sev_reg    <= out_sev_next;
        out_fill_reg   <= out_fill_next;
    end

endmodule

`default_nettype wire

>>> rtl/tlpl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tlpl_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              req_valid,
    input wire logic                              req_ready,
    input wire logic                              rsp_valid,
    input wire logic                              rsp_ready,
    input wire logic [tlpl_pkg::STATUS_W-1:0]     rsp_status,
    input wire logic [tlpl_pkg::TAG_W-1:0]        rsp_taken_tag,
    input wire logic [tlpl_pkg::SEV_W-1:0]        rsp_taken_severity,
    input wire logic [tlpl_pkg::FILL_W-1:0]       rsp_fill
);

    import tlpl_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_taken_tag) && $stable(rsp_taken_severity) && $stable(rsp_fill))
        else $error("response changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in progress");

    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_EMPTY |->
            rsp_fill == '0 && rsp_taken_tag == '0 && rsp_taken_severity == SEV_REGULAR)
        else $error("empty response carries data");

    a_no_take_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ST_ADDED || rsp_status == ST_FULL) |->
            rsp_taken_tag == '0 && rsp_taken_severity == SEV_REGULAR && rsp_fill != '0)
        else $error("add response carries taken entry");

    a_taken_sev: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_TAKEN |->
            (rsp_taken_severity == SEV_REGULAR || rsp_taken_severity == SEV_BAD
                || rsp_taken_severity == SEV_WORST))
        else $error("taken entry has invalid severity");

endmodule

bind three_level_priority_list tlpl_checker u_tlpl_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req.valid),
    .req_ready          (req.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_taken_tag      (rsp.taken_tag),
    .rsp_taken_severity (rsp.taken_severity),
    .rsp_fill           (rsp.fill)
);

`default_nettype wire
